>>> rtl/sats_pkg.sv
// Package for the sorted-aware table search: command codes, word types and the
// command and status groups between the controller and the datapath.
// No dependencies.
package sats_pkg;

  localparam int DefTableDepth = 16;
  localparam int ValueW        = 16;
  localparam int PosW          = 4;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [ValueW-1:0] value;
  } sats_in_t;

  typedef struct packed {
    logic            used_binary;
    logic            found;
    logic [PosW-1:0] position;
  } sats_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;
    logic append;
    logic search;
    logic bin_rd;
    logic bin_upd;
    logic lin_step;
    logic fin_hit;
    logic fin_miss;
  } sats_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sorted;
    logic bin_open;
    logic bin_eq;
    logic lin_hit;
    logic lin_done;
  } sats_stat_t;

endpackage

>>> rtl/sats_ctrl.sv
// Controller state machine of the sorted-aware table search.
// Depends on sats_pkg for the word types and the command and status groups.
module sats_ctrl import sats_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [1:0] command_i,
  input  sats_stat_t stat_i,
  output sats_ctl_t  ctl_o,
  output logic       busy_o
);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_BIN_RD  = 2'd1;
  localparam logic [1:0] S_BIN_CMP = 2'd2;
  localparam logic [1:0] S_LIN     = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          unique case (command_i)
            CMD_CLEAR:  ctl_o.clear = 1'b1;
            CMD_APPEND: ctl_o.append = 1'b1;
            CMD_SEARCH: begin
              ctl_o.search = 1'b1;
              state_d      = stat_i.sorted ? S_BIN_RD : S_LIN;
            end
            default: ;
          endcase
        end
      end
      S_BIN_RD: begin
        if (stat_i.bin_open) begin
          ctl_o.bin_rd = 1'b1;
          state_d      = S_BIN_CMP;
        end else begin
          ctl_o.fin_miss = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_BIN_CMP: begin
        if (stat_i.bin_eq) begin
          ctl_o.fin_hit = 1'b1;
          state_d       = S_IDLE;
        end else begin
          ctl_o.bin_upd = 1'b1;
          state_d       = S_BIN_RD;
        end
      end
      S_LIN: begin
        priority if (stat_i.lin_hit) begin
          ctl_o.fin_hit = 1'b1;
          state_d       = S_IDLE;
        end else if (stat_i.lin_done) begin
          ctl_o.fin_miss = 1'b1;
          state_d        = S_IDLE;
        end else begin
          ctl_o.lin_step = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // A search never ends in the same cycle as it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.search |=> busy_o)
    else $error("search taken without going busy");

  // Hit and miss never finish together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl_o.fin_hit && ctl_o.fin_miss))
    else $error("hit and miss finish at once");

  // Once a search finishes, the block is free on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_o.fin_hit || ctl_o.fin_miss) |=> !busy_o)
    else $error("still busy after a search finished");

endmodule

>>> rtl/sats_dpath.sv
// Datapath of the sorted-aware table search: ID memory, fill count, order flag,
// search pointers and the result register. Depends on sats_pkg.
module sats_dpath import sats_pkg::*; #(
  parameter int TABLE_DEPTH = DefTableDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  sats_in_t   item_i,
  input  sats_ctl_t  ctl_i,
  output sats_stat_t stat_o,
  output logic       done_o,
  output sats_out_t  result_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  logic [ValueW-1:0] mem_q [TABLE_DEPTH];
  logic [ValueW-1:0] rdata_q;
  logic [AW-1:0]     rd_addr;

  logic [CW-1:0]     count_q;
  logic              sorted_q;
  logic [ValueW-1:0] last_q;
  logic              done_q;
  logic              chk_valid_q;

  logic [ValueW-1:0] key_q;
  logic [CW-1:0]     lo_q, hi_q, mid_q, ptr_q;
  logic [AW-1:0]     chk_idx_q;
  sats_out_t         res_q;

  logic [CW-1:0]     mid;
  logic              room;
  logic              lin_issue;
  logic [AW-1:0]     hit_idx;
  logic [AW+3:0]     hit_ext;

  assign room      = (count_q < DepthC);
  // hi_q is one past the last candidate, so the midpoint is lo + (hi - 1 - lo) / 2.
  assign mid       = lo_q + ((hi_q - CW'(1) - lo_q) >> 1);
  assign lin_issue = ctl_i.lin_step && (ptr_q < count_q);
  assign rd_addr   = ctl_i.bin_rd ? mid[AW-1:0] : ptr_q[AW-1:0];
  assign hit_idx   = sorted_q ? mid_q[AW-1:0] : chk_idx_q;
  assign hit_ext   = {4'b0000, hit_idx};

  assign stat_o.sorted   = sorted_q;
  assign stat_o.bin_open = (lo_q < hi_q);
  assign stat_o.bin_eq   = (rdata_q == key_q);
  assign stat_o.lin_hit  = chk_valid_q && (rdata_q == key_q);
  assign stat_o.lin_done = !chk_valid_q && (ptr_q == count_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.append && room) begin
      mem_q[count_q[AW-1:0]] <= item_i.value;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sorted_q    <= 1'b1;
      last_q      <= '0;
      done_q      <= 1'b0;
      chk_valid_q <= 1'b0;
    end else begin
      done_q <= ctl_i.fin_hit || ctl_i.fin_miss;
      if (ctl_i.clear) begin
        count_q  <= '0;
        sorted_q <= 1'b1;
        last_q   <= '0;
      end else if (ctl_i.append && room) begin
        if ((count_q != '0) && (item_i.value < last_q)) begin
          sorted_q <= 1'b0;
        end
        count_q <= count_q + CW'(1);
        last_q  <= item_i.value;
      end
      if (ctl_i.search) begin
        chk_valid_q <= 1'b0;
      end else if (ctl_i.lin_step) begin
        chk_valid_q <= lin_issue;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.search) begin
      key_q <= item_i.value;
      lo_q  <= '0;
      hi_q  <= count_q;
      ptr_q <= '0;
    end
    if (ctl_i.bin_rd) begin
      mid_q <= mid;
    end
    if (ctl_i.bin_upd) begin
      if (rdata_q < key_q) begin
        lo_q <= mid_q + CW'(1);
      end else begin
        hi_q <= mid_q;
      end
    end
    if (lin_issue) begin
      chk_idx_q <= ptr_q[AW-1:0];
      ptr_q     <= ptr_q + CW'(1);
    end
    if (ctl_i.fin_hit || ctl_i.fin_miss) begin
      res_q.used_binary <= sorted_q;
      res_q.found       <= ctl_i.fin_hit;
      res_q.position    <= ctl_i.fin_hit ? hit_ext[PosW-1:0] : '0;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // The fill count never passes the table depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("fill count beyond table depth");

  // A clear leaves an empty table that counts as ordered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.clear |=> (count_q == '0) && sorted_q)
    else $error("clear did not empty the table");

  // A miss reports position zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && !res_q.found) |-> (res_q.position == '0))
    else $error("miss with non-zero position");

endmodule

>>> rtl/sorted_aware_table_search.sv
// Top level of the sorted-aware table search: controller plus datapath.
// Depends on sats_pkg, sats_ctrl and sats_dpath.
//
//   channel   handshake          word
//   command   start_i / busy_o   item_i   (command, value)
//   result    done_o strobe      result_o (used_binary, found, position)
//
// Clear, append and unused command codes are taken straight from idle; busy_o stays low.
// A binary search runs each probe as a registered memory read, then a compare,
// and narrows the candidate range after each compare.
// A linear scan reads one entry per cycle from the single memory read port.
// The result strobe is registered from the finishing step and follows in the next cycle.
// Reset clears the table count and the order flag; the ID memory is not cleared.
// The result strobe done_o is high for one cycle only; the receiver cannot stall.
module sorted_aware_table_search import sats_pkg::*; #(
  parameter int TABLE_DEPTH = DefTableDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  sats_in_t  item_i,
  output logic      busy_o,
  output logic      done_o,
  output sats_out_t result_o
);

  sats_ctl_t  ctl;
  sats_stat_t stat;

  sats_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_i),
    .command_i (item_i.command),
    .stat_i    (stat),
    .ctl_o     (ctl),
    .busy_o    (busy_o)
  );

  sats_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_i),
    .ctl_i    (ctl),
    .stat_o   (stat),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for sorted_aware_table_search: queue-fed command driver,
// result monitor and a table model that predicts every search answer.
// Depends on sats_pkg and the sorted_aware_table_search RTL.
module tb_top;
  import sats_pkg::*;

  localparam int          TableDepth  = DefTableDepth;
  localparam logic [1:0]  CmdUnused   = 2'd3;
  localparam int          TargetWords = 1200;
  localparam int          StallLimit  = 1000;
  localparam int          DrainCycles = 40;
  localparam int          MaxPrinted  = 40;

  logic      clk_i   = 1'b0;
  logic      rst_ni  = 1'b0;
  logic      start_i = 1'b0;
  sats_in_t  item_i  = '0;
  logic      busy_o;
  logic      done_o;
  sats_out_t result_o;

  sorted_aware_table_search #(
    .TABLE_DEPTH(TableDepth)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .item_i  (item_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Table model used for prediction.
  logic [ValueW-1:0] id_tab [TableDepth];
  int                tab_count  = 0;
  bit                tab_sorted = 1'b1;
  logic [ValueW-1:0] last_id    = '0;

  sats_in_t  pending_words[$];
  sats_out_t search_answers[$];

  // Generator's own view of the table contents, used to pick useful keys.
  logic [ValueW-1:0] gen_ids[$];
  int                words_queued = 0;

  int error_count    = 0;
  int words_taken    = 0;
  int binary_answers = 0;
  int linear_answers = 0;
  int hit_answers    = 0;
  int dropped_ids    = 0;
  int idle_left      = 0;
  bit calm_mode      = 1'b0;
  int stall_cycles   = 0;

  task automatic flag_error(input string msg);
    if (error_count < MaxPrinted) $display("ERROR @%0t: %s", $time, msg);
    error_count++;
  endtask

  // Applies one accepted word to the table model; a search leaves its answer queued.
  function automatic void apply_word(input sats_in_t w);
    sats_out_t ans;
    int        lo;
    int        hi;
    int        mid;
    int        where;
    bit        hit;
    lo    = 0;
    hi    = 0;
    where = 0;
    hit   = 1'b0;
    case (w.command)
      CMD_CLEAR: begin
        tab_count  = 0;
        tab_sorted = 1'b1;
        last_id    = '0;
      end
      CMD_APPEND: begin
        if (tab_count < TableDepth) begin
          if (tab_count > 0 && w.value < last_id) tab_sorted = 1'b0;
          id_tab[tab_count] = w.value;
          tab_count++;
          last_id = w.value;
        end else begin
          dropped_ids++;
        end
      end
      CMD_SEARCH: begin
        if (tab_sorted) begin
          hi = tab_count - 1;
          while (lo <= hi && !hit) begin
            mid = lo + (hi - lo) / 2;
            if (id_tab[mid] == w.value) begin
              hit   = 1'b1;
              where = mid;
            end else if (id_tab[mid] < w.value) begin
              lo = mid + 1;
            end else begin
              hi = mid - 1;
            end
          end
          binary_answers++;
        end else begin
          for (int i = 0; i < tab_count; i++) begin
            if (!hit && id_tab[i] == w.value) begin
              hit   = 1'b1;
              where = i;
            end
          end
          linear_answers++;
        end
        if (hit) hit_answers++;
        ans.used_binary = tab_sorted;
        ans.found       = hit;
        ans.position    = hit ? where[PosW-1:0] : '0;
        search_answers.push_back(ans);
      end
      default: begin
      end
    endcase
  endfunction

  task automatic queue_word(input logic [1:0] cmd, input logic [ValueW-1:0] val);
    sats_in_t w;
    w.command = cmd;
    w.value   = val;
    pending_words.push_back(w);
    if (cmd == CMD_CLEAR) gen_ids.delete();
    if (cmd == CMD_APPEND && gen_ids.size() < TableDepth) gen_ids.push_back(val);
    if (cmd != CmdUnused) words_queued++;
  endtask

  function automatic logic [ValueW-1:0] draw_value(input int style);
    logic [ValueW-1:0] v;
    case (style)
      0:       v = 16'($urandom_range(0, 7));
      1: begin
        case ($urandom_range(0, 3))
          0:       v = 16'h0000;
          1:       v = 16'h0001;
          2:       v = 16'hFFFE;
          default: v = 16'hFFFF;
        endcase
      end
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [ValueW-1:0] draw_key(input int style);
    int pick;
    pick = $urandom_range(0, 99);
    if (gen_ids.size() > 0 && pick < 60)
      return gen_ids[$urandom_range(0, gen_ids.size() - 1)];
    if (gen_ids.size() > 0 && pick < 75)
      return gen_ids[$urandom_range(0, gen_ids.size() - 1)] + ($urandom_range(0, 1) ? 16'd1
                                                                                    : 16'hFFFF);
    return draw_value(style);
  endfunction

  // One well-formed run: optional clear, a batch of IDs in a chosen order, then searches.
  task automatic queue_sequence();
    logic [ValueW-1:0] ids[$];
    logic [ValueW-1:0] tmp;
    int                n;
    int                style;
    int                order;
    int                k;
    n     = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 12);
    style = $urandom_range(0, 2);
    order = $urandom_range(0, 9);
    for (int i = 0; i < n; i++) ids.push_back(draw_value(style));
    if (order < 8) ids.sort();
    if (order >= 5 && order < 8 && n >= 2) begin
      k          = $urandom_range(0, n - 2);
      tmp        = ids[k];
      ids[k]     = ids[k + 1];
      ids[k + 1] = tmp;
    end
    if ($urandom_range(0, 4) != 0) queue_word(CMD_CLEAR, 16'($urandom));
    foreach (ids[i]) queue_word(CMD_APPEND, ids[i]);
    repeat ($urandom_range(1, 6)) queue_word(CMD_SEARCH, draw_key(style));
  endtask

  // Driver: holds start_i until the block takes the word, then waits a drawn gap.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    logic     nxt_start;
    sats_in_t nxt_item;
    if (!rst_ni) begin
      start_i   <= 1'b0;
      item_i    <= '0;
      idle_left = 0;
    end else begin
      nxt_start = start_i;
      nxt_item  = item_i;
      if (start_i && !busy_o) begin
        apply_word(item_i);
        words_taken++;
        nxt_start = 1'b0;
        if ($urandom_range(0, 39) == 0) calm_mode = !calm_mode;
        idle_left = calm_mode ? 0 : $urandom_range(0, 7);
      end
      if (!nxt_start) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (pending_words.size() > 0) begin
          nxt_item  = pending_words.pop_front();
          nxt_start = 1'b1;
        end
      end
      start_i <= nxt_start;
      item_i  <= nxt_item;
    end
  end

  // Monitor: every strobed result must match the oldest outstanding search.
  always @(posedge clk_i) begin : monitor_proc
    sats_out_t want;
    if (rst_ni && done_o) begin
      if (search_answers.size() == 0) begin
        flag_error("result strobe with no search outstanding");
      end else begin
        want = search_answers.pop_front();
        if (result_o.used_binary !== want.used_binary)
          flag_error($sformatf("used_binary %b, expected %b",
                               result_o.used_binary, want.used_binary));
        if (result_o.found !== want.found)
          flag_error($sformatf("found %b, expected %b", result_o.found, want.found));
        if (result_o.position !== want.position)
          flag_error($sformatf("position %0d, expected %0d",
                               result_o.position, want.position));
      end
    end
  end

  // Watchdog on cycles in which neither a command word nor a result moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("watchdog: no progress for %0d cycles", StallLimit);
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    // Directed part: empty table, ignored code, order broken by the second ID,
    // clear with stale entries left behind, then a full table and a dropped ID.
    queue_word(CMD_SEARCH, 16'h0000);
    queue_word(CmdUnused, 16'hFFFF);
    queue_word(CMD_APPEND, 16'hFFFF);
    queue_word(CMD_APPEND, 16'h0000);
    queue_word(CMD_SEARCH, 16'h0000);
    queue_word(CMD_SEARCH, 16'h1234);
    queue_word(CMD_CLEAR, 16'hA5A5);
    queue_word(CMD_SEARCH, 16'hFFFF);
    for (int i = 0; i < TableDepth; i++)
      queue_word(CMD_APPEND, (i == TableDepth - 1) ? 16'hFFFF : 16'(i * 4096 / 3));
    queue_word(CMD_APPEND, 16'h0000);
    queue_word(CMD_SEARCH, 16'hFFFF);
    queue_word(CMD_SEARCH, 16'h0000);

    while (words_queued < TargetWords) begin
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 4)) queue_word(2'($urandom_range(0, 3)), 16'($urandom));
      end else begin
        queue_sequence();
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() > 0 || start_i) @(posedge clk_i);
    while (search_answers.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d command words taken, %0d binary and %0d linear searches, %0d hits",
             words_taken, binary_answers, linear_answers, hit_answers);
    $display("%0d IDs dropped on a full table, %0d mismatches", dropped_ids, error_count);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
